### hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants of the sorted list unit
// Opcodes, status codes, cell commands and the control word that the top
// level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sli_pkg;

	// Field widths of one beat.
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 7;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Commands to the cells.
	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_ROTATE = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Broadcast control word for the chain.
	typedef struct packed {
		logic [1:0] cmd;
		value_t     key;
	} cell_ctl_t;

endpackage

### hw/rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one entry of the sorted chain
// Holds one value and its occupied flag, compares it with the broadcast key,
// and on command keeps it, takes the key, a neighbor's value or the head value.
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sli_pkg::cell_ctl_t ctl,
	input  sli_pkg::value_t    left_val,
	input  logic               left_occ,
	input  logic               left_lt,
	input  sli_pkg::value_t    right_val,
	input  logic               right_occ,
	input  sli_pkg::value_t    head_val,
	output sli_pkg::value_t    val,
	output logic               occ,
	output logic               lt,
	output logic               eq
);

	sli_pkg::value_t val_q;
	logic            occ_q;
	logic            lt_q;
	logic            eq_q;

	// Compare flags, taken every cycle against the current key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else begin
			lt_q <= occ_q && (val_q < ctl.key);
			eq_q <= occ_q && (val_q == ctl.key);
		end
	end

	// Occupied flag; the occupied cells always form a prefix of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				sli_pkg::CMD_INSERT: begin
					occ_q <= occ_q | left_occ;
				end
				sli_pkg::CMD_REMOVE: begin
					if (!lt_q) begin
						occ_q <= right_occ;
					end
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

	// Insert/remove shift cells not below the key by one; rotate wraps.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			sli_pkg::CMD_INSERT: begin
				if (!lt_q) begin
					val_q <= left_lt ? ctl.key : left_val;
				end
			end
			sli_pkg::CMD_REMOVE: begin
				if (!lt_q) begin
					val_q <= right_val;
				end
			end
			sli_pkg::CMD_ROTATE: begin
				val_q <= right_occ ? right_val : head_val;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign val = val_q;
	assign occ = occ_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

### hw/rtl/sorted_list_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit: bounded sorted table of signed words
// A chain of DEPTH compare-and-shift cells keeps the values in ascending
// order; inserts and removes move all cells at once, a dump rotates the chain.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Fields
//  command   start / busy           opcode, value
//  result    result_strobe          status, element, stored_count, last
//
//  Insert and remove pass the latch, the cell compares and the shift before
//  the result beat. Unused opcodes, refused inserts, removes from an empty
//  table and a dump of an empty table answer from the compare state.
//  A dump of N stored values gives N beats, one beat per cycle as the
//  chain rotates. Reset clears the count and the occupied flags.
//  The receiver cannot stall; busy falls in the cycle that carries the last beat.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [sli_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [sli_pkg::VALUE_W-1:0]  value,
	output logic                                result_strobe,
	output logic [sli_pkg::STATUS_W-1:0]        status,
	output logic signed [sli_pkg::VALUE_W-1:0]  element,
	output logic [sli_pkg::COUNT_W-1:0]         stored_count,
	output logic                                last
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CMP   = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_DUMP  = 2'd3;

	logic [1:0]                   state_q;
	logic [1:0]                   state_d;
	logic [sli_pkg::OPCODE_W-1:0] op_q;
	sli_pkg::value_t              key_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_d;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                idx_d;
	sli_pkg::cell_ctl_t           ctl;
	logic                         found;

	// Result register.
	logic                         strobe_q;
	logic                         strobe_d;
	logic [sli_pkg::STATUS_W-1:0] status_q;
	logic [sli_pkg::STATUS_W-1:0] status_d;
	sli_pkg::value_t              element_q;
	sli_pkg::value_t              element_d;
	logic [CW-1:0]                rcount_q;
	logic [CW-1:0]                rcount_d;
	logic                         last_q;
	logic                         last_d;

	// Chain signals with a sentinel at each end: index 0 is left of cell 0,
	// index DEPTH+1 is right of the last cell.
	sli_pkg::value_t val_x [DEPTH+2];
	logic [DEPTH+1:0] occ_x;
	logic [DEPTH:0]   lt_x;
	logic [DEPTH-1:0] eq_w;

	assign val_x[0]       = '0;
	assign occ_x[0]       = 1'b1;
	assign lt_x[0]        = 1'b1;
	assign val_x[DEPTH+1] = '0;
	assign occ_x[DEPTH+1] = 1'b0;

	// The cell chain.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sli_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_val  (val_x[i]),
			.left_occ  (occ_x[i]),
			.left_lt   (lt_x[i]),
			.right_val (val_x[i+2]),
			.right_occ (occ_x[i+2]),
			.head_val  (val_x[1]),
			.val       (val_x[i+1]),
			.occ       (occ_x[i+1]),
			.lt        (lt_x[i+1]),
			.eq        (eq_w[i])
		);
	end

	// The value is present if any cell matched the key.
	assign found = |eq_w;

	// Sequencer and result selection.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		ctl.cmd   = sli_pkg::CMD_HOLD;
		ctl.key   = key_q;
		strobe_d  = 1'b0;
		status_d  = sli_pkg::ST_OK;
		element_d = '0;
		rcount_d  = count_q;
		last_d    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d  = S_IDLE;
				strobe_d = 1'b1;
				case (op_q)
					sli_pkg::OP_INSERT: begin
						if (count_q == DEPTH_C) begin
							status_d = sli_pkg::ST_FULL;
						end else begin
							state_d  = S_APPLY;
							strobe_d = 1'b0;
						end
					end
					sli_pkg::OP_REMOVE: begin
						if (count_q == '0) begin
							status_d = sli_pkg::ST_EMPTY;
						end else begin
							state_d  = S_APPLY;
							strobe_d = 1'b0;
						end
					end
					sli_pkg::OP_DUMP: begin
						if (count_q == '0) begin
							status_d = sli_pkg::ST_EMPTY;
						end else begin
							state_d  = S_DUMP;
							strobe_d = 1'b0;
							idx_d    = '0;
						end
					end
					default: begin
						status_d = sli_pkg::ST_OK;
					end
				endcase
			end
			S_APPLY: begin
				state_d  = S_IDLE;
				strobe_d = 1'b1;
				if (op_q == sli_pkg::OP_INSERT) begin
					ctl.cmd  = sli_pkg::CMD_INSERT;
					count_d  = count_q + ONE_C;
				end else if (found) begin
					ctl.cmd  = sli_pkg::CMD_REMOVE;
					count_d  = count_q - ONE_C;
				end else begin
					status_d = sli_pkg::ST_NOT_FOUND;
				end
				rcount_d = count_d;
			end
			S_DUMP: begin
				ctl.cmd   = sli_pkg::CMD_ROTATE;
				strobe_d  = 1'b1;
				element_d = val_x[1];
				last_d    = (idx_q == count_q - ONE_C);
				idx_d     = idx_q + ONE_C;
				if (last_d) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			strobe_q <= strobe_d;
		end
	end

	// Command latch and result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= opcode;
			key_q <= value;
		end
		status_q  <= status_d;
		element_q <= element_d;
		rcount_q  <= rcount_d;
		last_q    <= last_d;
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign element       = element_q;
	assign stored_count  = sli_pkg::COUNT_W'(rcount_q);
	assign last          = last_q;

endmodule

### hw/rtl/sli_checker.sv
// ----------------------------------------------------------------------------
// sli_checker: port-level checks of the sorted list unit
// Watches the command and result channels and flags beats that break the
// sequencing of results.
// ----------------------------------------------------------------------------
module sli_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [sli_pkg::STATUS_W-1:0]       status,
	input logic signed [sli_pkg::VALUE_W-1:0] element,
	input logic [sli_pkg::COUNT_W-1:0]        stored_count,
	input logic                               result_strobe,
	input logic                               last
);

	// An accepted command keeps the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after an accepted command");

	// A dump streams its beats with no gap until the last one.
	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> result_strobe)
		else $error("gap inside a dump burst");

	// Every beat that is not last belongs to a busy unit.
	a_busy_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("unit idle while a burst continues");

	// Error beats end the command and carry no element.
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && status != sli_pkg::ST_OK |-> last && element == '0)
		else $error("error beat with element or without last");

	// An empty report shows a zero count and the count never exceeds the depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (stored_count <= sli_pkg::COUNT_W'(DEPTH)) &&
			(status != sli_pkg::ST_EMPTY || stored_count == '0))
		else $error("stored count out of range");

endmodule

bind sorted_list_insert_remove_unit sli_checker #(.DEPTH(DEPTH)) u_sli_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.status        (status),
	.element       (element),
	.stored_count  (stored_count),
	.result_strobe (result_strobe),
	.last          (last)
);

### test/sorted_list_insert_remove_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit_tb: self-checking bench for the sorted table
// The bench drives commands with random gaps and keeps its own copy of the
// table. Every result beat is compared field by field, in order, against that
// copy. Directed tests cover the empty table, extreme values and the full
// table. A long random phase then fills and drains the table many times.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit_tb;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 205;
	localparam int SETTLE_CYCLES = 40;

	// The block ignores this opcode apart from reporting the count.
	localparam logic [sli_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [sli_pkg::STATUS_W-1:0] status;
		sli_pkg::value_t              element;
		logic [sli_pkg::COUNT_W-1:0]  stored_count;
		logic                         last;
	} result_beat_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [sli_pkg::OPCODE_W-1:0] opcode = sli_pkg::OP_INSERT;
	sli_pkg::value_t              value = '0;
	logic                         busy;
	logic                         result_strobe;
	logic [sli_pkg::STATUS_W-1:0] status;
	sli_pkg::value_t              element;
	logic [sli_pkg::COUNT_W-1:0]  stored_count;
	logic                         last;

	// Shadow copy of the table contents, kept in ascending order.
	sli_pkg::value_t shadow_table[TABLE_DEPTH];
	int              shadow_count = 0;
	result_beat_t    pending_beats[$];
	result_beat_t    oldest_beat;

	int  error_count = 0;
	int  beats_checked = 0;
	int  commands_sent = 0;
	int  dumps_sent = 0;
	int  full_refusals = 0;
	int  missed_removes = 0;
	int  empty_reports = 0;
	bit  burst_mode = 1'b0;

	sorted_list_insert_remove_unit #(
		.DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.value(value),
		.result_strobe(result_strobe),
		.status(status),
		.element(element),
		.stored_count(stored_count),
		.last(last)
	);

	// Free-running 50 MHz clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Queue one expected beat, tagged with the count after the command.
	function automatic void expect_beat(logic [sli_pkg::STATUS_W-1:0] st,
		sli_pkg::value_t elem, logic is_last);
		result_beat_t beat;
		beat.status = st;
		beat.element = elem;
		beat.stored_count = shadow_count[sli_pkg::COUNT_W-1:0];
		beat.last = is_last;
		pending_beats.push_back(beat);
	endfunction

	// Apply one accepted command to the shadow table and queue its beats.
	function automatic void apply_to_shadow(logic [sli_pkg::OPCODE_W-1:0] op,
		sli_pkg::value_t v);
		int pos;
		int i;
		case (op)
			sli_pkg::OP_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					full_refusals++;
					expect_beat(sli_pkg::ST_FULL, '0, 1'b1);
				end else begin
					// The new value goes before the first entry that is not smaller.
					pos = 0;
					while (pos < shadow_count && shadow_table[pos] < v)
						pos++;
					for (i = shadow_count; i > pos; i--)
						shadow_table[i] = shadow_table[i - 1];
					shadow_table[pos] = v;
					shadow_count++;
					expect_beat(sli_pkg::ST_OK, '0, 1'b1);
				end
			end
			sli_pkg::OP_REMOVE: begin
				if (shadow_count == 0) begin
					empty_reports++;
					expect_beat(sli_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_table[pos] != v)
						pos++;
					if (pos >= shadow_count) begin
						missed_removes++;
						expect_beat(sli_pkg::ST_NOT_FOUND, '0, 1'b1);
					end else begin
						for (i = pos; i + 1 < shadow_count; i++)
							shadow_table[i] = shadow_table[i + 1];
						shadow_count--;
						expect_beat(sli_pkg::ST_OK, '0, 1'b1);
					end
				end
			end
			sli_pkg::OP_DUMP: begin
				dumps_sent++;
				if (shadow_count == 0) begin
					empty_reports++;
					expect_beat(sli_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < shadow_count; i++)
						expect_beat(sli_pkg::ST_OK, shadow_table[i],
							i == shadow_count - 1);
				end
			end
			default: begin
				expect_beat(sli_pkg::ST_OK, '0, 1'b1);
			end
		endcase
	endfunction

	// Present one command after a random gap and wait until it is accepted.
	// Start stays high on return so that a back-to-back command keeps it up.
	task automatic send_command(input logic [sli_pkg::OPCODE_W-1:0] op,
		input sli_pkg::value_t v);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(19, 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		value <= v;
		do @(posedge clk); while (busy);
		apply_to_shadow(op, v);
		commands_sent++;
	endtask

	// Dump, remove and an unused opcode against an empty table.
	task automatic test_empty_table;
		send_command(sli_pkg::OP_DUMP, sli_pkg::value_t'(32'h1234_5678));
		send_command(sli_pkg::OP_REMOVE, sli_pkg::value_t'(7));
		send_command(OP_UNUSED, sli_pkg::value_t'(-1));
	endtask

	// Extremes of the value range, a duplicate, an absent value, a dump and a remove.
	task automatic test_extreme_values;
		send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(32'h7FFF_FFFF));
		send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(32'h8000_0000));
		send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(0));
		send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(-1));
		send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(0));
		send_command(sli_pkg::OP_REMOVE, sli_pkg::value_t'(5));
		send_command(sli_pkg::OP_DUMP, sli_pkg::value_t'(32'hFFFF_FFFF));
		send_command(sli_pkg::OP_REMOVE, sli_pkg::value_t'(0));
	endtask

	// Fill the table, then try one insert too many, dump it and poke it.
	task automatic test_full_table;
		int n;
		n = 0;
		while (shadow_count < TABLE_DEPTH) begin
			case (n % 3)
				0: send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(32'h5555_5555));
				1: send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(32'hAAAA_AAAA));
				default: send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'($urandom));
			endcase
			n++;
		end
		send_command(sli_pkg::OP_INSERT, sli_pkg::value_t'(1));
		send_command(sli_pkg::OP_DUMP, sli_pkg::value_t'(0));
		send_command(OP_UNUSED, sli_pkg::value_t'(32'h8000_0000));
	endtask

	// Random traffic that swings between filling and draining the table.
	// Removes mostly pick a stored value, inserts often reuse small values.
	task automatic test_random_traffic;
		int n;
		int pick;
		bit filling;
		logic [sli_pkg::OPCODE_W-1:0] op;
		sli_pkg::value_t v;
		filling = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			burst_mode = ((n / 40) % 2) == 1;
			if (shadow_count >= TABLE_DEPTH)
				filling = 1'b0;
			else if (shadow_count == 0)
				filling = 1'b1;
			else if ($urandom_range(19, 0) == 0)
				filling = ~filling;

			pick = $urandom_range(99, 0);
			if (pick < 3)
				op = OP_UNUSED;
			else if (pick < 12)
				op = sli_pkg::OP_DUMP;
			else if (pick < (filling ? 74 : 38))
				op = sli_pkg::OP_INSERT;
			else
				op = sli_pkg::OP_REMOVE;

			if ($urandom_range(1, 0) == 1)
				v = sli_pkg::value_t'($urandom);
			else
				v = sli_pkg::value_t'(int'($urandom_range(8, 0)) - 4);
			if (op == sli_pkg::OP_REMOVE && shadow_count > 0 && $urandom_range(3, 0) != 0)
				v = shadow_table[$urandom_range(shadow_count - 1, 0)];
			send_command(op, v);
		end
		burst_mode = 1'b0;
	endtask

	// Compare each result beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected result beat: status %0d element %0d count %0d last %0d",
					status, element, stored_count, last);
				error_count++;
			end else begin
				oldest_beat = pending_beats.pop_front();
				beats_checked++;
				if (status !== oldest_beat.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						oldest_beat.status, status);
					error_count++;
				end
				if (element !== oldest_beat.element) begin
					$error("element mismatch: expected %0d, actual %0d",
						oldest_beat.element, element);
					error_count++;
				end
				if (stored_count !== oldest_beat.stored_count) begin
					$error("stored_count mismatch: expected %0d, actual %0d",
						oldest_beat.stored_count, stored_count);
					error_count++;
				end
				if (last !== oldest_beat.last) begin
					$error("last mismatch: expected %0d, actual %0d",
						oldest_beat.last, last);
					error_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed tests, random traffic, then drain.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_extreme_values();
		test_full_table();
		test_random_traffic();
		start <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0) begin
			$error("%0d expected result beats never arrived", pending_beats.size());
			error_count++;
		end

		$display("Sent %0d commands (%0d dumps) and checked %0d result beats.",
			commands_sent, dumps_sent, beats_checked);
		$display("Saw %0d refused inserts, %0d removes of absent values, %0d empty reports.",
			full_refusals, missed_removes, empty_reports);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
